// ===== rtl/core/u8dec_pkg.sv =====
`timescale 1ns / 1ps
// Package for the UTF-8 to UCS-2 stream decoder: shared types, constants and helpers.
// No dependencies. Used by every module of the decoder.
package u8dec_pkg;

  // Width of the per-string character counter.
  localparam int COUNT_BITS = 16;
  localparam int CMP_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // Depth of the queue between the front and the back.
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Continuation bytes still expected.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] E0_CONT_MIN = 8'hA0;
  localparam logic [7:0] CONT_LIMIT = 8'h40;

  // Classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_zero;
    logic       is_ascii;
    logic       lead2;
    logic       lead3;
    logic       is_e0;
    logic       is_cont;
    logic       ge_a0;
  } byte_info_t;

  // Clamp a counter value to the 16-bit count field.
  function automatic logic [15:0] sat16(input logic [COUNT_BITS-1:0] cnt);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(cnt);
    if (ext > CMP_W'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return ext[15:0];
  endfunction

endpackage

// ===== rtl/core/u8dec_front.sv =====
`timescale 1ns / 1ps
// Front end of the decoder: accepts bytes and classifies them for the back end.
// Depends on u8dec_pkg.
module u8dec_front import u8dec_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output byte_info_t q_data_o
);

  logic [7:0] cont_bits;

  assign cont_bits  = in_byte_i ^ CONT_MARK;
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o          = '0;
    q_data_o.data     = in_byte_i;
    q_data_o.last     = in_last_i;
    q_data_o.is_zero  = (in_byte_i == 8'h00);
    q_data_o.is_ascii = (in_byte_i < CONT_MARK);
    q_data_o.lead2    = (in_byte_i >= LEAD2_MIN) && (in_byte_i < LEAD3_MIN);
    q_data_o.lead3    = (in_byte_i >= LEAD3_MIN) && (in_byte_i < LEAD4_MIN);
    q_data_o.is_e0    = (in_byte_i == LEAD_E0);
    q_data_o.is_cont  = (cont_bits < CONT_LIMIT);
    q_data_o.ge_a0    = (in_byte_i >= E0_CONT_MIN);
  end

endmodule

// ===== rtl/core/u8dec_fifo.sv =====
`timescale 1ns / 1ps
// Short queue of classified bytes between the front and the back end.
// Depends on u8dec_pkg.
module u8dec_fifo import u8dec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  byte_info_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output byte_info_t pop_data_o
);

  byte_info_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o     = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/u8dec_back.sv =====
`timescale 1ns / 1ps
// Back end of the decoder: string state, character assembly, limit and result register.
// Depends on u8dec_pkg.
module u8dec_back import u8dec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        char_limit_we_i,
  input  logic [15:0] char_limit_i,
  input  logic        q_empty_i,
  input  byte_info_t  q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        is_error_o,
  output logic        has_char_o,
  output logic        end_of_string_o,
  output logic [15:0] char_count_o
);

  logic [15:0]           limit_q;
  logic [1:0]            pend_q, pend_d;
  logic [9:0]            part_q, part_d;
  logic                  e0_q, e0_d;
  logic                  disc_q, disc_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  logic                  valid_q, valid_d;
  logic [15:0]           code_q, code_d;
  logic                  err_q, err_d;
  logic                  has_q, has_d;
  logic                  eos_q, eos_d;
  logic [15:0]           ccnt_q, ccnt_d;

  logic                  out_free;
  logic                  res_valid;
  logic [5:0]            cbits;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [CMP_W-1:0]      cnt_inc_ext, limit_ext;
  logic                  closes;

  assign out_free    = !valid_q || !out_stall_i;
  assign q_pop_o     = !q_empty_i && out_free;
  assign cbits       = q_data_i.data[5:0];
  assign cnt_inc     = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);
  assign cnt_inc_ext = CMP_W'(cnt_inc);
  assign limit_ext   = CMP_W'(limit_q);
  assign closes      = q_data_i.last || ((limit_q != '0) && (cnt_inc_ext >= limit_ext));

  always_comb begin
    pend_d    = pend_q;
    part_d    = part_q;
    e0_d      = e0_q;
    disc_d    = disc_q;
    cnt_d     = cnt_q;
    res_valid = 1'b0;
    code_d    = '0;
    err_d     = 1'b0;
    has_d     = 1'b0;
    eos_d     = 1'b0;
    ccnt_d    = sat16(cnt_q);

    if (disc_q) begin
      if (q_data_i.last || q_data_i.is_zero) begin
        disc_d = 1'b0;
        cnt_d  = '0;
      end
    end else if ((pend_q == PEND_NONE) && q_data_i.is_zero) begin
      // Bare end of string.
      res_valid = 1'b1;
      eos_d     = 1'b1;
      cnt_d     = '0;
    end else if (((pend_q == PEND_NONE) && q_data_i.is_ascii) ||
                 ((pend_q == PEND_ONE) && q_data_i.is_cont)) begin
      // A character completes.
      res_valid = 1'b1;
      has_d     = 1'b1;
      eos_d     = closes;
      ccnt_d    = sat16(cnt_inc);
      code_d    = (pend_q == PEND_NONE) ? {8'h00, q_data_i.data} : {part_q, cbits};
      pend_d    = PEND_NONE;
      part_d    = '0;
      e0_d      = 1'b0;
      if (q_data_i.last) begin
        cnt_d = '0;
      end else begin
        cnt_d  = cnt_inc;
        disc_d = closes;
      end
    end else if (((pend_q == PEND_NONE) && (q_data_i.lead2 || q_data_i.lead3) &&
                  !q_data_i.last) ||
                 ((pend_q == PEND_TWO) && q_data_i.is_cont && !q_data_i.last &&
                  !(e0_q && !q_data_i.ge_a0))) begin
      // Sequence continues without a result.
      if (pend_q == PEND_TWO) begin
        pend_d = PEND_ONE;
        part_d = {part_q[3:0], cbits};
        e0_d   = 1'b0;
      end else if (q_data_i.lead2) begin
        pend_d = PEND_ONE;
        part_d = {5'b0, q_data_i.data[4:0]};
        e0_d   = 1'b0;
      end else begin
        pend_d = PEND_TWO;
        part_d = {6'b0, q_data_i.data[3:0]};
        e0_d   = q_data_i.is_e0;
      end
    end else begin
      // Invalid lead, bad continuation, overlong form or truncation.
      res_valid = 1'b1;
      err_d     = 1'b1;
      eos_d     = 1'b1;
      pend_d    = PEND_NONE;
      part_d    = '0;
      e0_d      = 1'b0;
      if (q_data_i.last) begin
        cnt_d = '0;
      end else begin
        disc_d = 1'b1;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (out_free) begin
      valid_d = q_pop_o && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      pend_q  <= PEND_NONE;
      part_q  <= '0;
      e0_q    <= 1'b0;
      disc_q  <= 1'b0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (char_limit_we_i) begin
        limit_q <= char_limit_i;
      end
      if (q_pop_o) begin
        pend_q <= pend_d;
        part_q <= part_d;
        e0_q   <= e0_d;
        disc_q <= disc_d;
        cnt_q  <= cnt_d;
      end
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && res_valid) begin
      code_q <= code_d;
      err_q  <= err_d;
      has_q  <= has_d;
      eos_q  <= eos_d;
      ccnt_q <= ccnt_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign code_unit_o     = code_q;
  assign is_error_o      = err_q;
  assign has_char_o      = has_q;
  assign end_of_string_o = eos_q;
  assign char_count_o    = ccnt_q;

  // While dropping bytes no multi-byte sequence may be open.
  a_disc_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (pend_q == PEND_NONE))
    else $error("discarding with a sequence still open");

  // The E0 flag only lives while the second byte of a three-byte form is awaited.
  a_e0_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e0_q |-> (pend_q == PEND_TWO))
    else $error("E0 flag set outside the first continuation");

  // An error result never carries a character and always closes the string.
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && err_q) |-> (!has_q && eos_q && (code_q == 16'h0000)))
    else $error("malformed error result");

  // A result that stalls downstream blocks any further pop from the queue.
  a_no_pop_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |-> !q_pop_o)
    else $error("queue popped while result register is held");

endmodule

// ===== rtl/core/utf8_to_ucs2_stream_decoder.sv =====
`timescale 1ns / 1ps
// UTF-8 to UCS-2 stream decoder, one byte in per cycle unless the input is stalled. Each
// byte is classified on entry and parked in a two-entry queue; the back end pops one byte per
// cycle unless the result register is held, updates the string state and loads at most one
// transaction into the result register as it pops the byte. The sustained rate is one byte
// per clock while the result side does not stall. A stall on the result side fills the
// queue within two bytes, after which the input is stalled. No clearing pass is needed
// after reset. The user must write the character limit only while the block is idle;
// the block itself does not enforce this.
// Depends on u8dec_pkg, u8dec_front, u8dec_fifo and u8dec_back.
module utf8_to_ucs2_stream_decoder import u8dec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        char_limit_we_i,
  input  logic [15:0] char_limit_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        is_error_o,
  output logic        has_char_o,
  output logic        end_of_string_o,
  output logic [15:0] char_count_o
);

  logic       q_full, q_empty, q_push, q_pop;
  byte_info_t q_in, q_out;

  u8dec_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  u8dec_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_out)
  );

  u8dec_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .char_limit_we_i (char_limit_we_i),
    .char_limit_i    (char_limit_i),
    .q_empty_i       (q_empty),
    .q_data_i        (q_out),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_unit_o     (code_unit_o),
    .is_error_o      (is_error_o),
    .has_char_o      (has_char_o),
    .end_of_string_o (end_of_string_o),
    .char_count_o    (char_count_o)
  );

endmodule

// ===== tb/utf8_to_ucs2_stream_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_ucs2_stream_decoder: predicts every output transaction
// with a behavioral decoder and compares it field by field. Depends on u8dec_pkg and the RTL.
module utf8_to_ucs2_stream_decoder_tb;
  import u8dec_pkg::*;

  localparam int CycleLimit = 3_000_000;
  localparam int IdleTail   = 8;
  localparam int DrainLimit = 2000;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_error;
    logic        has_char;
    logic        end_of_string;
    logic [15:0] char_count;
  } unit_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        char_limit_we_i = 1'b0;
  logic [15:0] char_limit_i    = '0;
  logic        in_valid_i      = 1'b0;
  logic [7:0]  in_byte_i       = '0;
  logic        in_last_i       = 1'b0;
  logic        out_stall_i     = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [15:0] code_unit_o;
  logic        is_error_o;
  logic        has_char_o;
  logic        end_of_string_o;
  logic [15:0] char_count_o;

  utf8_to_ucs2_stream_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .char_limit_we_i(char_limit_we_i),
    .char_limit_i   (char_limit_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_unit_o    (code_unit_o),
    .is_error_o     (is_error_o),
    .has_char_o     (has_char_o),
    .end_of_string_o(end_of_string_o),
    .char_count_o   (char_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Decoder state as the block should hold it.
  logic [1:0]            cont_left = PEND_NONE;
  logic [9:0]            acc_bits  = '0;
  logic                  saw_e0    = 1'b0;
  logic                  skipping  = 1'b0;
  logic [COUNT_BITS-1:0] str_chars = '0;
  logic [15:0]           limit_reg = '0;

  unit_result_t expected_units[$];

  int mismatches     = 0;
  int results_seen   = 0;
  int chars_seen     = 0;
  int error_closes   = 0;
  int bytes_sent     = 0;
  int strings_sent   = 0;
  int limit_settings = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int stall_run      = 0;
  bit stall_now      = 1'b0;

  function automatic void reset_string();
    cont_left = PEND_NONE;
    acc_bits  = '0;
    saw_e0    = 1'b0;
    skipping  = 1'b0;
    str_chars = '0;
  endfunction

  function automatic void push_result(logic [15:0] cu, logic err, logic has, logic eos);
    unit_result_t r;
    r.code_unit     = cu;
    r.is_error      = err;
    r.has_char      = has;
    r.end_of_string = eos;
    r.char_count    = (str_chars > COUNT_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(str_chars);
    expected_units.push_back(r);
  endfunction

  function automatic void report_error(logic last);
    push_result(16'h0000, 1'b1, 1'b0, 1'b1);
    if (last) begin
      reset_string();
    end else begin
      cont_left = PEND_NONE;
      acc_bits  = '0;
      saw_e0    = 1'b0;
      skipping  = 1'b1;
    end
  endfunction

  function automatic void finish_char(logic [15:0] cu, logic last);
    logic closes;
    if (str_chars != '1) begin
      str_chars = str_chars + 1'b1;
    end
    closes = last || (limit_reg != 0 && str_chars >= limit_reg);
    push_result(cu, 1'b0, 1'b1, closes);
    cont_left = PEND_NONE;
    acc_bits  = '0;
    saw_e0    = 1'b0;
    if (last) begin
      reset_string();
    end else if (closes) begin
      skipping = 1'b1;
    end
  endfunction

  // Advances the predicted state by one accepted byte.
  function automatic void decode_byte(logic [7:0] b, logic last);
    logic [7:0] c;
    c = b ^ CONT_MARK;
    if (skipping) begin
      if (last || b == 8'h00) begin
        reset_string();
      end
    end else if (cont_left == PEND_NONE) begin
      if (b == 8'h00) begin
        push_result(16'h0000, 1'b0, 1'b0, 1'b1);
        reset_string();
      end else if (b < CONT_MARK) begin
        finish_char({8'h00, b}, last);
      end else if (b < LEAD2_MIN || b >= LEAD4_MIN || last) begin
        report_error(last);
      end else if (b < LEAD3_MIN) begin
        cont_left = PEND_ONE;
        acc_bits  = {5'b0, b[4:0]};
        saw_e0    = 1'b0;
      end else begin
        cont_left = PEND_TWO;
        acc_bits  = {6'b0, b[3:0]};
        saw_e0    = (b == LEAD_E0);
      end
    end else if (c >= CONT_LIMIT || (cont_left == PEND_TWO && saw_e0 && b < E0_CONT_MIN)) begin
      report_error(last);
    end else if (cont_left == PEND_ONE) begin
      finish_char({acc_bits, c[5:0]}, last);
    end else begin
      acc_bits  = {acc_bits[3:0], c[5:0]};
      cont_left = PEND_ONE;
      saw_e0    = 1'b0;
      if (last) begin
        report_error(last);
      end
    end
  endfunction

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h, actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    unit_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (has_char_o) chars_seen++;
      if (is_error_o) error_closes++;
      if (expected_units.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, actual code_unit %h eos %b",
                 $time, code_unit_o, end_of_string_o);
      end else begin
        want = expected_units.pop_front();
        check_field("code_unit", want.code_unit, code_unit_o);
        check_field("is_error", 16'(want.is_error), 16'(is_error_o));
        check_field("has_char", 16'(want.has_char), 16'(has_char_o));
        check_field("end_of_string", 16'(want.end_of_string), 16'(end_of_string_o));
        check_field("char_count", want.char_count, char_count_o);
      end
    end
  end

  // Receiver backpressure: random runs of stalled and free cycles.
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_now = ($urandom_range(0, 99) < 30);
      stall_run = $urandom_range(1, stall_now ? 4 : 10);
    end
    stall_run--;
    out_stall_i <= stall_now;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the byte was accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_seq(input byte_q_t seq, input bit last_on_end);
    foreach (seq[i]) begin
      send_byte(seq[i], last_on_end && (i == seq.size() - 1));
    end
    strings_sent++;
  endtask

  // Waits for every predicted transaction, then lets the pipeline settle.
  task automatic drain();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (expected_units.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_units.size() != 0) begin
      mismatches++;
      $display("%0t: %0d transactions expected, actual none arrived", $time,
               expected_units.size());
      expected_units.delete();
    end
    repeat (IdleTail) @(posedge clk_i);
  endtask

  task automatic set_char_limit(input logic [15:0] v);
    drain();
    char_limit_we_i <= 1'b1;
    char_limit_i    <= v;
    @(posedge clk_i);
    char_limit_we_i <= 1'b0;
    limit_reg = v;
    limit_settings++;
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  task automatic send_random_string();
    byte_q_t seq;
    int      n_chars;
    int      pos;
    bit      zero_end;
    n_chars  = $urandom_range(0, 10);
    zero_end = ($urandom_range(0, 3) == 0);
    repeat (n_chars) begin
      case ($urandom_range(0, 3))
        0: seq.push_back(8'($urandom_range(1, 8'h7F)));
        1: begin
          seq.push_back(8'($urandom_range(LEAD2_MIN, 8'hDF)));
          seq.push_back(cont_byte());
        end
        2: begin
          seq.push_back(LEAD_E0);
          seq.push_back(8'($urandom_range(E0_CONT_MIN, 8'hBF)));
          seq.push_back(cont_byte());
        end
        default: begin
          seq.push_back(8'($urandom_range(8'hE1, 8'hEF)));
          seq.push_back(cont_byte());
          seq.push_back(cont_byte());
        end
      endcase
    end
    // A fifth of the non-empty strings get a random byte or are cut short.
    if (seq.size() > 0 && $urandom_range(0, 99) < 20) begin
      pos = $urandom_range(0, seq.size() - 1);
      if ($urandom_range(0, 1)) begin
        seq[pos] = 8'($urandom);
      end else begin
        seq = seq[0:pos];
      end
    end
    if (zero_end || seq.size() == 0) begin
      seq.push_back(8'h00);
      send_seq(seq, 1'b0);
    end else begin
      send_seq(seq, 1'b1);
    end
  endtask

  task automatic test_single_bytes();
    send_seq('{8'h7F, 8'h00}, 1'b0);
    send_seq('{8'h00}, 1'b0);
    send_seq('{8'h01}, 1'b1);
  endtask

  task automatic test_multi_byte();
    send_seq('{8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hED, 8'hA0, 8'h80}, 1'b1);
  endtask

  task automatic test_bad_sequences();
    // Overlong E0 form, then a zero byte that ends the dropped string silently.
    send_seq('{8'hE0, 8'h9F, 8'h41, 8'h00}, 1'b0);
    send_seq('{8'hC2, 8'h00, 8'hFF}, 1'b1);
    send_seq('{8'h80}, 1'b1);
    send_seq('{8'hE1, 8'h80}, 1'b1);
    send_seq('{8'hF5, 8'h41}, 1'b1);
  endtask

  task automatic test_char_limit();
    set_char_limit(16'd2);
    send_byte(8'h41, 1'b0);
    // Lowering the limit mid-string takes effect on the next character.
    set_char_limit(16'd1);
    send_seq('{8'h42, 8'h43, 8'h00}, 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [15:0] limits[6];
    int          stop_at;
    limits = '{16'd0, 16'd1, 16'd3, 16'($urandom_range(2, 9)), 16'hFFFF, 16'($urandom)};
    foreach (limits[p]) begin
      set_char_limit(limits[p]);
      stop_at = bytes_sent + 170;
      while (bytes_sent < stop_at) send_random_string();
    end
  endtask

  initial begin
    reset_string();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_bytes();
    test_multi_byte();
    test_bad_sequences();
    test_char_limit();
    test_random_traffic();
    drain();
    $display("Sent %0d bytes in %0d strings under %0d limit settings.",
             bytes_sent, strings_sent, limit_settings);
    $display("Checked %0d transactions: %0d characters, %0d error closes, %0d mismatches.",
             results_seen, chars_seen, error_closes, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/u8dec_pkg.sv
rtl/core/u8dec_front.sv
rtl/core/u8dec_fifo.sv
rtl/core/u8dec_back.sv
rtl/core/utf8_to_ucs2_stream_decoder.sv
tb/utf8_to_ucs2_stream_decoder_tb.sv
